@@ rtl/core/snappy_pkg.sv @@
// Package for the Snappy block decompressor: beat types, status codes and sizes.
// Used by every file under rtl/core; depends on nothing.
package snappy_pkg;

    localparam int HistorySize = 65536;
    localparam int HistAw = $clog2(HistorySize);
    localparam int MaxCopyRun = 64;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_LEN_TRUNC    = 4'd1,
        ST_LEN_INVALID  = 4'd2,
        ST_LITLEN_TRUNC = 4'd3,
        ST_LIT_TRUNC    = 4'd4,
        ST_LIT_OVERSIZE = 4'd5,
        ST_OFF_TRUNC    = 4'd6,
        ST_OFF_INVALID  = 4'd7,
        ST_COPY_OVER    = 4'd8,
        ST_SHORT        = 4'd9,
        ST_TRAILING     = 4'd10,
        ST_BEYOND_WIN   = 4'd11
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       block_done;
        logic [3:0] status;
    } out_beat_t;

endpackage

@@ rtl/core/snappy_block_decompressor.sv @@
// Snappy raw block decompressor: the parser, the copy sequencer and the output stage.
// Depends on snappy_pkg and snappy_hist.
//
// Compressed bytes enter one per beat. A header, tag or field byte is parsed as it
// enters, and a literal byte gives one output beat. A copy uses the single read port
// of the history ring once per output byte and takes no new input byte until its
// last byte has gone to the output stage. Output stalls hold the parser and the copy.
// The ring holds HistorySize bytes and needs no clearing after reset, because offsets
// are checked against the bytes produced.
module snappy_block_decompressor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  snappy_pkg::in_beat_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output snappy_pkg::out_beat_t out_data
);

    localparam int Aw = snappy_pkg::HistAw;

    typedef enum logic [3:0] {
        PH_LEN, PH_TAG, PH_LITLEN, PH_LIT, PH_LIT_OVER, PH_COPYOFF, PH_DONE
    } phase_t;

    typedef enum logic [1:0] { SQ_IDLE, SQ_READ, SQ_WAIT, SQ_EMIT } seq_t;

    phase_t      phase_reg, phase_next;
    seq_t        seq_reg, seq_next;
    logic [31:0] decl_reg, decl_next;
    logic [2:0]  shift_reg, shift_next;
    logic [31:0] prod_reg, prod_next;
    logic [32:0] litrem_reg, litrem_next;
    logic [6:0]  clen_reg, clen_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  left_reg, left_next;
    logic        err_reg, err_next;
    logic        last_reg, last_next;
    logic [31:0] off_reg, off_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        ov_reg, ov_next;
    snappy_pkg::out_beat_t ob_reg, ob_next;

    logic        wr_en;
    logic [Aw-1:0] wr_addr, rd_addr;
    logic [7:0]  wr_data, rd_data;

    logic        take;
    logic        slot_free;
    logic [7:0]  b;
    logic [31:0] room;
    logic [31:0] acc_new;
    logic [31:0] b32;
    logic [4:0]  vsh;

    assign slot_free = !ov_reg || !out_stall;
    assign in_stall  = (seq_reg != SQ_IDLE) || !slot_free;
    assign take      = in_valid && !in_stall;
    assign b         = in_data.in_byte;
    assign b32       = {24'd0, b};
    assign room      = decl_reg - prod_reg;
    assign out_valid = ov_reg;
    assign out_data  = ob_reg;
    assign rd_addr   = Aw'(prod_reg - off_reg);

    snappy_hist u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    function automatic snappy_pkg::status_t end_status(input phase_t ph);
        case (ph)
            PH_LEN:      return snappy_pkg::ST_LEN_TRUNC;
            PH_LITLEN:   return snappy_pkg::ST_LITLEN_TRUNC;
            PH_LIT:      return snappy_pkg::ST_LIT_TRUNC;
            PH_LIT_OVER: return snappy_pkg::ST_LIT_TRUNC;
            PH_COPYOFF:  return snappy_pkg::ST_OFF_TRUNC;
            PH_DONE:     return snappy_pkg::ST_OK;
            default:     return snappy_pkg::ST_SHORT;
        endcase
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        decl_next   = decl_reg;
        shift_next  = shift_reg;
        prod_next   = prod_reg;
        litrem_next = litrem_reg;
        clen_next   = clen_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        err_next    = err_reg;
        last_next   = last_reg;
        off_next    = off_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg && out_stall;
        ob_next     = ob_reg;
        wr_en       = 1'b0;
        wr_addr     = Aw'(prod_reg);
        wr_data     = b;
        acc_new     = acc_reg | (b32 << {shift_reg[1:0], 3'b000});
        vsh         = 5'd0;

        if (seq_reg != SQ_IDLE)
        begin
            case (seq_reg)
                SQ_READ:
                begin
                    seq_next = SQ_WAIT;
                end
                SQ_WAIT:
                begin
                    if (slot_free)
                    begin
                        wr_en     = 1'b1;
                        wr_data   = rd_data;
                        prod_next = prod_reg + 32'd1;
                        cnt_next  = cnt_reg - 7'd1;
                        ov_next   = 1'b1;
                        ob_next   = '{rd_data, 1'b0, 1'b0, snappy_pkg::ST_OK};
                        if (cnt_reg == 7'd1)
                        begin
                            seq_next = SQ_IDLE;
                            ob_next.run_last = 1'b1;
                            phase_next = (prod_reg + 32'd1 == decl_reg) ? PH_DONE : PH_TAG;
                            if (last_reg)
                            begin
                                ob_next.status = end_status(phase_next);
                                ob_next.block_done = (phase_next == PH_DONE);
                                phase_next = PH_LEN;
                                decl_next = '0;
                                shift_next = '0;
                                prod_next = '0;
                                litrem_next = '0;
                                clen_next = '0;
                                acc_next = '0;
                                left_next = '0;
                            end
                        end
                        else
                        begin
                            seq_next = SQ_READ;
                        end
                    end
                end
                default:
                begin
                    seq_next = SQ_IDLE;
                end
            endcase
        end
        else if (take)
        begin
            logic [3:0] err;
            logic       emit;
            logic       copy;
            err  = snappy_pkg::ST_OK;
            emit = 1'b0;
            copy = 1'b0;
            if (err_reg)
            begin
                if (in_data.in_last)
                begin
                    err_next = 1'b0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        if (shift_reg >= 3'd4 && b[7:4] != 4'd0)
                        begin
                            err = snappy_pkg::ST_LEN_INVALID;
                        end
                        else
                        begin
                            vsh = (shift_reg > 3'd4) ? 5'd28 : 5'(shift_reg) * 5'd7;
                            decl_next = decl_reg | ({25'd0, b[6:0]} << vsh);
                            if (b[7])
                            begin
                                shift_next = (shift_reg > 3'd4) ? 3'd5 : shift_reg + 3'd1;
                            end
                            else
                            begin
                                shift_next = '0;
                                phase_next = (decl_next == 32'd0) ? PH_DONE : PH_TAG;
                            end
                        end
                    end
                    PH_TAG:
                    begin
                        acc_next = '0;
                        shift_next = '0;
                        if (b[1:0] == 2'd0)
                        begin
                            if (b[7:2] < 6'd60)
                            begin
                                litrem_next = {27'd0, b[7:2]} + 33'd1;
                                phase_next = ({26'd0, b[7:2]} + 32'd1 > room)
                                             ? PH_LIT_OVER : PH_LIT;
                            end
                            else
                            begin
                                left_next = 3'(b[7:2] - 6'd59);
                                phase_next = PH_LITLEN;
                            end
                        end
                        else
                        begin
                            if (b[1:0] == 2'd1)
                            begin
                                clen_next = 7'd4 + {4'd0, b[4:2]};
                                acc_next = {21'd0, b[7:5], 8'd0};
                                left_next = 3'd1;
                            end
                            else
                            begin
                                clen_next = 7'd1 + {1'b0, b[7:2]};
                                left_next = (b[1:0] == 2'd2) ? 3'd2 : 3'd4;
                            end
                            phase_next = PH_COPYOFF;
                        end
                    end
                    PH_LITLEN:
                    begin
                        acc_next = acc_new;
                        shift_next = shift_reg + 3'd1;
                        left_next = left_reg - 3'd1;
                        if (left_reg == 3'd1)
                        begin
                            litrem_next = {1'b0, acc_new} + 33'd1;
                            phase_next = ({1'b0, acc_new} + 33'd1 > {1'b0, room})
                                         ? PH_LIT_OVER : PH_LIT;
                        end
                    end
                    PH_LIT:
                    begin
                        wr_en = 1'b1;
                        emit = 1'b1;
                        prod_next = prod_reg + 32'd1;
                        litrem_next = litrem_reg - 33'd1;
                        if (litrem_reg == 33'd1)
                        begin
                            phase_next = (prod_next == decl_reg) ? PH_DONE : PH_TAG;
                        end
                    end
                    PH_LIT_OVER:
                    begin
                        litrem_next = litrem_reg - 33'd1;
                        if (litrem_reg == 33'd1)
                        begin
                            err = snappy_pkg::ST_LIT_OVERSIZE;
                        end
                    end
                    PH_COPYOFF:
                    begin
                        acc_next = acc_new;
                        shift_next = shift_reg + 3'd1;
                        left_next = left_reg - 3'd1;
                        if (left_reg == 3'd1)
                        begin
                            if (acc_new == 32'd0 || acc_new > prod_reg)
                            begin
                                err = snappy_pkg::ST_OFF_INVALID;
                            end
                            else if ({25'd0, clen_reg} > room)
                            begin
                                err = snappy_pkg::ST_COPY_OVER;
                            end
                            else if (acc_new > 32'(snappy_pkg::HistorySize))
                            begin
                                err = snappy_pkg::ST_BEYOND_WIN;
                            end
                            else
                            begin
                                copy = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        err = snappy_pkg::ST_TRAILING;
                    end
                endcase

                if (copy)
                begin
                    off_next = acc_new;
                    cnt_next = clen_reg;
                    last_next = in_data.in_last;
                    seq_next = SQ_READ;
                end
                else if (err != snappy_pkg::ST_OK)
                begin
                    ov_next = 1'b1;
                    ob_next = '{8'd0, 1'b1, 1'b0, err};
                    err_next = !in_data.in_last;
                end
                else if (emit || in_data.in_last)
                begin
                    ov_next = 1'b1;
                    ob_next = '{emit ? b : 8'd0, 1'b1, 1'b0, snappy_pkg::ST_OK};
                    if (in_data.in_last)
                    begin
                        ob_next.status = end_status(phase_next);
                        ob_next.block_done = (phase_next == PH_DONE);
                    end
                end

                if ((err != snappy_pkg::ST_OK || in_data.in_last) && !copy)
                begin
                    phase_next = PH_LEN;
                    decl_next = '0;
                    shift_next = '0;
                    prod_next = '0;
                    litrem_next = '0;
                    clen_next = '0;
                    acc_next = '0;
                    left_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            seq_reg    <= SQ_IDLE;
            decl_reg   <= '0;
            shift_reg  <= '0;
            prod_reg   <= '0;
            litrem_reg <= '0;
            clen_reg   <= '0;
            acc_reg    <= '0;
            left_reg   <= '0;
            err_reg    <= 1'b0;
            last_reg   <= 1'b0;
            off_reg    <= '0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
            ob_reg     <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            decl_reg   <= decl_next;
            shift_reg  <= shift_next;
            prod_reg   <= prod_next;
            litrem_reg <= litrem_next;
            clen_reg   <= clen_next;
            acc_reg    <= acc_next;
            left_reg   <= left_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
            off_reg    <= off_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
            ob_reg     <= ob_next;
        end
    end

endmodule

@@ rtl/core/snappy_hist.sv @@
// History ring of the Snappy decompressor: one write port, one registered read port.
// Depends on snappy_pkg.
module snappy_hist (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [snappy_pkg::HistAw-1:0] wr_addr,
    input  logic [7:0]                   wr_data,
    input  logic [snappy_pkg::HistAw-1:0] rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0] mem [snappy_pkg::HistorySize];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/snappy_checker.sv @@
// Port checker for the Snappy block decompressor, bound to the top level.
// Depends on snappy_pkg.
module snappy_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input snappy_pkg::out_beat_t out_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled output beat changed.");

    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.block_done |-> out_data.status == snappy_pkg::ST_OK
            && out_data.run_last)
        else $error("Block done without ok status.");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != snappy_pkg::ST_OK |-> out_data.run_last)
        else $error("Status on a beat that is not last.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= snappy_pkg::ST_BEYOND_WIN)
        else $error("Status code out of range.");

endmodule

bind snappy_block_decompressor snappy_checker u_snappy_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
